// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, disabled while reset is asserted
`define LCAT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion that is also checked during reset
`define LCAT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/lcat_pkg.sv -----
// shared constants for the load cell readout with tare
package lcat_pkg;

    // field and register widths
    localparam int SAMPLE_W = 24;
    localparam int GRAMS_W  = 25;
    localparam int CFG_W    = 24;
    localparam int PULSE_W  = 5;
    localparam int CNT4_W   = 4;

    // serial clock pulses per conversion read, data bits per read
    localparam logic [PULSE_W-1:0] PULSES    = 5'd25;
    localparam logic [PULSE_W-1:0] DATA_BITS = 5'd24;

    // request kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_TARE  = 2'd1;
    localparam logic [1:0] KIND_WEIGH = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_WEIGHT    = 2'd0;
    localparam logic [1:0] STATUS_TARE      = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT   = 2'd2;
    localparam logic [1:0] STATUS_NOT_TARED = 2'd3;

    // configuration register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_CPG     = 1'b1;

    // configuration reset values
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 24'd200000;
    localparam logic [CFG_W-1:0] CPG_RESET     = 24'd2280;

endpackage

// ----- rtl/core/lcat_divider.sv -----
// bit-serial signed by unsigned divider, truncating toward zero
module lcat_divider
    import lcat_pkg::*;
#(
    parameter int QW = 28
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [QW-1:0] dividend,
    input  logic [CFG_W-1:0]     divisor,
    output logic                 done,
    output logic signed [QW-1:0] quotient
);

    localparam int CNT_W = $clog2(QW);

    typedef enum logic [1:0] {D_IDLE, D_ABS, D_RUN, D_FIX} div_state_t;

    div_state_t       state_reg, state_next;
    logic [QW-1:0]    num_reg, num_next;
    logic [CFG_W-1:0] den_reg, den_next;
    logic [CFG_W-1:0] rem_reg, rem_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [QW-1:0]    quot_reg, quot_next;

    // one restoring step: shift in the next dividend bit, trial subtract
    logic [CFG_W:0]   rem_sh;
    logic [CFG_W+1:0] trial;
    logic             borrow;

    assign rem_sh = {rem_reg, num_reg[QW-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, den_reg};
    assign borrow = trial[CFG_W+1];

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        quot_next  = quot_reg;
        case (state_reg)
            D_IDLE: begin
                if (start) begin
                    num_next   = dividend;
                    den_next   = divisor;
                    neg_next   = dividend[QW-1];
                    state_next = D_ABS;
                end
            end
            D_ABS: begin
                if (neg_reg) begin
                    num_next = ~num_reg + QW'(1);
                end
                rem_next   = '0;
                cnt_next   = '0;
                state_next = D_RUN;
            end
            D_RUN: begin
                rem_next = borrow ? rem_sh[CFG_W-1:0] : trial[CFG_W-1:0];
                num_next = {num_reg[QW-2:0], ~borrow};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QW - 1)) begin
                    state_next = D_FIX;
                end
            end
            D_FIX: begin
                quot_next  = neg_reg ? (~num_reg + QW'(1)) : num_reg;
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            num_reg   <= '0;
            den_reg   <= '0;
            rem_reg   <= '0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            quot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            num_reg   <= num_next;
            den_reg   <= den_next;
            rem_reg   <= rem_next;
            neg_reg   <= neg_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            quot_reg  <= quot_next;
        end
    end

    assign done     = done_reg;
    assign quotient = $signed(quot_reg);

endmodule

// ----- rtl/core/load_cell_adc_reader_with_tare.sv -----
// top level: load cell converter readout with tare and serial divider
//
// Each input request is one tick of the converter interface: it carries the
// sampled data line and a request kind (plain tick, start tare, start weigh).
// Each request produces exactly one result on the m_ channel: the serial clock
// level to drive for that tick, busy and done flags, status, the last sample,
// the weight in grams and the stored tare offset.
// A tare or weigh first waits for the data line to go low (with a timeout in
// ticks), then clocks 25 pulses and shifts in a 24-bit sample MSB first.
// A tick that needs no division passes the pending result register, then the
// output register. The tick that ends a weigh with a good sample, or a tare
// with at least one good sample, runs the bit-serial divider: one quotient
// bit a cycle over the tare sum width (28 bits at the default).
// One request is worked on at a time; s_ready is high whenever the core is
// idle, also while a finished result waits in the output register. If the
// receiver stalls, the finished result of the next request holds in the core
// until the output register frees up. Reset (aresetn low, synchronous) clears
// the sequence, tare and outputs and loads the configuration defaults
// (timeout 200000 ticks, 2280 counts/gram). Configuration is written through
// cfg_wr_en/cfg_addr/cfg_wdata; the user must do so while idle (not enforced).
module load_cell_adc_reader_with_tare
    import lcat_pkg::*;
#(
    parameter int TARE_SAMPLES = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration write port
    input  logic                       cfg_wr_en,
    input  logic                       cfg_addr,
    input  logic [CFG_W-1:0]           cfg_wdata,
    // input request channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_kind,
    input  logic                       s_data_line,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_clock_line,
    output logic                       m_busy_res,
    output logic                       m_done_res,
    output logic [1:0]                 m_status,
    output logic signed [SAMPLE_W-1:0] m_raw_sample,
    output logic signed [GRAMS_W-1:0]  m_grams,
    output logic signed [SAMPLE_W-1:0] m_tare_value
);

    // tare sum holds up to TARE_SAMPLES signed 24-bit samples
    localparam int SUM_W = SAMPLE_W + $clog2(TARE_SAMPLES + 1);

    typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_HIGH, PH_LOW} phase_t;
    typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} ctl_t;

    // configuration
    logic [CFG_W-1:0] timeout_reg, timeout_next;
    logic [CFG_W-1:0] cpg_reg, cpg_next;

    // readout sequence state
    phase_t                     phase_reg, phase_next;
    logic                       taring_reg, taring_next;
    logic [PULSE_W-1:0]         pulse_reg, pulse_next;
    logic [CFG_W-1:0]           wait_reg, wait_next;
    logic [SAMPLE_W-1:0]        shift_reg, shift_next;
    logic [CNT4_W-1:0]          samples_reg, samples_next;
    logic [CNT4_W-1:0]          good_reg, good_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0] zero_reg, zero_next;
    logic                       tared_reg, tared_next;
    logic signed [SAMPLE_W-1:0] last_reg, last_next;

    // pending result and control
    ctl_t                       ctl_reg, ctl_next;
    logic                       res_clk_reg, res_clk_next;
    logic                       res_done_reg, res_done_next;
    logic [1:0]                 res_status_reg, res_status_next;
    logic signed [GRAMS_W-1:0]  grams_reg, grams_next;
    logic                       div_start_reg, div_start_next;
    logic                       div_tare_reg, div_tare_next;

    // output register
    logic                       m_valid_reg, m_valid_next;
    logic                       o_clk_reg, o_clk_next;
    logic                       o_busy_reg, o_busy_next;
    logic                       o_done_reg, o_done_next;
    logic [1:0]                 o_status_reg, o_status_next;
    logic signed [SAMPLE_W-1:0] o_raw_reg, o_raw_next;
    logic signed [GRAMS_W-1:0]  o_grams_reg, o_grams_next;
    logic signed [SAMPLE_W-1:0] o_tare_reg, o_tare_next;

    // read completion of this tick
    logic accepted;
    logic end_rd;
    logic rd_ok;

    // divider hookup
    logic signed [SUM_W-1:0] div_dividend;
    logic [CFG_W-1:0]        div_divisor;
    logic                    div_done;
    logic signed [SUM_W-1:0] div_quot;

    assign s_ready  = (ctl_reg == S_IDLE);
    assign accepted = s_valid && s_ready;

    // dividend and divisor for the tare average or the weigh
    always_comb begin
        if (div_tare_reg) begin
            div_dividend = sum_reg;
            div_divisor  = CFG_W'(good_reg);
        end else begin
            div_dividend = SUM_W'(last_reg) - SUM_W'(zero_reg);
            div_divisor  = (cpg_reg == '0) ? CFG_W'(1) : cpg_reg;
        end
    end

    lcat_divider #(
        .QW(SUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // tick sequencing, division hand-off and output register
    always_comb begin
        timeout_next    = timeout_reg;
        cpg_next        = cpg_reg;
        phase_next      = phase_reg;
        taring_next     = taring_reg;
        pulse_next      = pulse_reg;
        wait_next       = wait_reg;
        shift_next      = shift_reg;
        samples_next    = samples_reg;
        good_next       = good_reg;
        sum_next        = sum_reg;
        zero_next       = zero_reg;
        tared_next      = tared_reg;
        last_next       = last_reg;
        ctl_next        = ctl_reg;
        res_clk_next    = res_clk_reg;
        res_done_next   = res_done_reg;
        res_status_next = res_status_reg;
        grams_next      = grams_reg;
        div_start_next  = 1'b0;
        div_tare_next   = div_tare_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        o_clk_next      = o_clk_reg;
        o_busy_next     = o_busy_reg;
        o_done_next     = o_done_reg;
        o_status_next   = o_status_reg;
        o_raw_next      = o_raw_reg;
        o_grams_next    = o_grams_reg;
        o_tare_next     = o_tare_reg;
        end_rd          = 1'b0;
        rd_ok           = 1'b0;

        // configuration writes
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_TIMEOUT: timeout_next = cfg_wdata;
                CFG_CPG:     cpg_next     = cfg_wdata;
                default:     ;
            endcase
        end

        case (ctl_reg)
            S_IDLE: begin
                if (accepted) begin
                    res_clk_next    = 1'b0;
                    res_done_next   = 1'b0;
                    res_status_next = STATUS_WEIGHT;
                    grams_next      = '0;
                    ctl_next        = S_DONE;

                    // one tick of the readout sequence
                    case (phase_reg)
                        PH_IDLE: begin
                            case (s_kind)
                                KIND_TARE: begin
                                    taring_next  = 1'b1;
                                    samples_next = '0;
                                    good_next    = '0;
                                    sum_next     = '0;
                                    wait_next    = '0;
                                    phase_next   = PH_WAIT;
                                end
                                KIND_WEIGH: begin
                                    if (!tared_reg) begin
                                        res_done_next   = 1'b1;
                                        res_status_next = STATUS_NOT_TARED;
                                    end else begin
                                        taring_next = 1'b0;
                                        wait_next   = '0;
                                        phase_next  = PH_WAIT;
                                    end
                                end
                                KIND_TICK: ;
                                default:   ;
                            endcase
                        end
                        PH_WAIT: begin
                            if (!s_data_line) begin
                                pulse_next = '0;
                                shift_next = '0;
                                phase_next = PH_HIGH;
                            end else if (wait_reg >= timeout_reg) begin
                                end_rd = 1'b1;
                            end else begin
                                wait_next = wait_reg + CFG_W'(1);
                            end
                        end
                        PH_HIGH: begin
                            res_clk_next = 1'b1;
                            if (pulse_reg < DATA_BITS) begin
                                shift_next = {shift_reg[SAMPLE_W-2:0], s_data_line};
                            end
                            phase_next = PH_LOW;
                        end
                        PH_LOW: begin
                            pulse_next = pulse_reg + PULSE_W'(1);
                            if (pulse_next >= PULSES) begin
                                last_next = $signed(shift_reg);
                                end_rd    = 1'b1;
                                rd_ok     = 1'b1;
                            end else begin
                                phase_next = PH_HIGH;
                            end
                        end
                        default: begin
                            phase_next = PH_IDLE;
                        end
                    endcase

                    // end of one conversion read
                    if (end_rd) begin
                        if (taring_reg) begin
                            samples_next = samples_reg + CNT4_W'(1);
                            if (rd_ok) begin
                                sum_next  = sum_reg + SUM_W'(last_next);
                                good_next = good_reg + CNT4_W'(1);
                            end
                            if (samples_next >= CNT4_W'(TARE_SAMPLES)) begin
                                tared_next      = 1'b1;
                                phase_next      = PH_IDLE;
                                res_done_next   = 1'b1;
                                res_status_next = STATUS_TARE;
                                if (good_next != '0) begin
                                    div_start_next = 1'b1;
                                    div_tare_next  = 1'b1;
                                    ctl_next       = S_DIV;
                                end else begin
                                    zero_next = '0;
                                end
                            end else begin
                                wait_next  = '0;
                                phase_next = PH_WAIT;
                            end
                        end else begin
                            phase_next    = PH_IDLE;
                            res_done_next = 1'b1;
                            if (rd_ok) begin
                                res_status_next = STATUS_WEIGHT;
                                div_start_next  = 1'b1;
                                div_tare_next   = 1'b0;
                                ctl_next        = S_DIV;
                            end else begin
                                res_status_next = STATUS_TIMEOUT;
                            end
                        end
                    end
                end
            end
            S_DIV: begin
                // take the quotient into the offset or the weight
                if (div_done) begin
                    if (div_tare_reg) begin
                        zero_next = $signed(div_quot[SAMPLE_W-1:0]);
                    end else begin
                        grams_next = $signed(div_quot[GRAMS_W-1:0]);
                    end
                    ctl_next = S_DONE;
                end
            end
            S_DONE: begin
                // move the finished result into the output register
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    o_clk_next    = res_clk_reg;
                    o_busy_next   = (phase_reg != PH_IDLE);
                    o_done_next   = res_done_reg;
                    o_status_next = res_status_reg;
                    o_raw_next    = last_reg;
                    o_grams_next  = grams_reg;
                    o_tare_next   = zero_reg;
                    ctl_next      = S_IDLE;
                end
            end
            default: begin
                ctl_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg    <= TIMEOUT_RESET;
            cpg_reg        <= CPG_RESET;
            phase_reg      <= PH_IDLE;
            taring_reg     <= 1'b0;
            pulse_reg      <= '0;
            wait_reg       <= '0;
            shift_reg      <= '0;
            samples_reg    <= '0;
            good_reg       <= '0;
            sum_reg        <= '0;
            zero_reg       <= '0;
            tared_reg      <= 1'b0;
            last_reg       <= '0;
            ctl_reg        <= S_IDLE;
            res_clk_reg    <= 1'b0;
            res_done_reg   <= 1'b0;
            res_status_reg <= STATUS_WEIGHT;
            grams_reg      <= '0;
            div_start_reg  <= 1'b0;
            div_tare_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            o_clk_reg      <= 1'b0;
            o_busy_reg     <= 1'b0;
            o_done_reg     <= 1'b0;
            o_status_reg   <= STATUS_WEIGHT;
            o_raw_reg      <= '0;
            o_grams_reg    <= '0;
            o_tare_reg     <= '0;
        end else begin
            timeout_reg    <= timeout_next;
            cpg_reg        <= cpg_next;
            phase_reg      <= phase_next;
            taring_reg     <= taring_next;
            pulse_reg      <= pulse_next;
            wait_reg       <= wait_next;
            shift_reg      <= shift_next;
            samples_reg    <= samples_next;
            good_reg       <= good_next;
            sum_reg        <= sum_next;
            zero_reg       <= zero_next;
            tared_reg      <= tared_next;
            last_reg       <= last_next;
            ctl_reg        <= ctl_next;
            res_clk_reg    <= res_clk_next;
            res_done_reg   <= res_done_next;
            res_status_reg <= res_status_next;
            grams_reg      <= grams_next;
            div_start_reg  <= div_start_next;
            div_tare_reg   <= div_tare_next;
            m_valid_reg    <= m_valid_next;
            o_clk_reg      <= o_clk_next;
            o_busy_reg     <= o_busy_next;
            o_done_reg     <= o_done_next;
            o_status_reg   <= o_status_next;
            o_raw_reg      <= o_raw_next;
            o_grams_reg    <= o_grams_next;
            o_tare_reg     <= o_tare_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_clock_line = o_clk_reg;
    assign m_busy_res   = o_busy_reg;
    assign m_done_res   = o_done_reg;
    assign m_status     = o_status_reg;
    assign m_raw_sample = o_raw_reg;
    assign m_grams      = o_grams_reg;
    assign m_tare_value = o_tare_reg;

endmodule

// ----- rtl/core/lcat_checker.sv -----
// port-level checker for the load cell readout, bound to the top level
`include "assert_macros.svh"

module lcat_checker
    import lcat_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       cfg_wr_en,
    input logic                       cfg_addr,
    input logic [CFG_W-1:0]           cfg_wdata,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic [1:0]                 s_kind,
    input logic                       s_data_line,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_clock_line,
    input logic                       m_busy_res,
    input logic                       m_done_res,
    input logic [1:0]                 m_status,
    input logic signed [SAMPLE_W-1:0] m_raw_sample,
    input logic signed [GRAMS_W-1:0]  m_grams,
    input logic signed [SAMPLE_W-1:0] m_tare_value
);

    // status only carries meaning on a finished request
    `LCAT_ASSERT(a_status_idle, aclk, aresetn, m_valid && !m_done_res |-> m_status == STATUS_WEIGHT, "status set without done")

    // a nonzero weight only comes with a successful weigh
    `LCAT_ASSERT(a_grams_weigh, aclk, aresetn, m_valid && m_grams != 0 |-> m_done_res && m_status == STATUS_WEIGHT, "grams outside a weigh result")

    // an untared weigh ends at once and leaves the block idle
    `LCAT_ASSERT(a_not_tared_idle, aclk, aresetn, m_valid && m_done_res && m_status == STATUS_NOT_TARED |-> !m_busy_res && !m_clock_line, "not-tared result while busy")

    // a stalled result holds
    `LCAT_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_grams) && $stable(m_tare_value), "stalled result changed")

    // reset empties the output register
    `LCAT_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind load_cell_adc_reader_with_tare lcat_checker u_lcat_checker (.*);
